// ===== rtl/uniform_envelope_interpolator_defines.svh =====
`ifndef UNIFORM_ENVELOPE_INTERPOLATOR_DEFINES_SVH
`define UNIFORM_ENVELOPE_INTERPOLATOR_DEFINES_SVH

// Same-cycle check on clk, off while rst_n is low.
`define UEI_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uei assertion failed");

// Next-cycle check on clk, off while rst_n is low.
`define UEI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uei assertion failed");

`endif

// ===== rtl/uei_pkg.sv =====
package uei_pkg;

  localparam int SEG_BITS    = 5;
  localparam int T_BITS      = 17;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_BITS    = 6;
  localparam int PROD_T_BITS = T_BITS + SEG_BITS;
  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;

  localparam logic [T_BITS-1:0] ONE_Q16 = 17'h10000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [PADDR_BITS-1:0] ADDR_SEGMENT_COUNT = 3'd0;

  typedef struct packed {
    logic [FRAC_BITS-1:0] frac;
    logic                 err;
  } uei_meta_t;

endpackage

// ===== rtl/uei_in_if.sv =====
interface uei_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [4:0]                   entry_index;
  logic signed [VALUE_BITS-1:0] lower_value;
  logic signed [VALUE_BITS-1:0] upper_value;
  logic [16:0]                  param_t;

  modport source (
    output valid, command, entry_index, lower_value, upper_value, param_t,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, lower_value, upper_value, param_t,
    output ready
  );
endinterface

// ===== rtl/uei_out_if.sv =====
interface uei_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] lower_result;
  logic signed [VALUE_BITS-1:0] upper_result;
  logic                         out_of_range;

  modport source (
    output valid, lower_result, upper_result, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, lower_result, upper_result, out_of_range,
    output ready
  );
endinterface

// ===== rtl/uei_ram.sv =====
module uei_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/uei_cfg.sv =====
module uei_cfg #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [uei_pkg::PADDR_BITS-1:0] paddr,
  input  logic [uei_pkg::PDATA_BITS-1:0] pwdata,
  output logic [uei_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  output logic [uei_pkg::SEG_BITS-1:0]   seg_count
);
  import uei_pkg::*;

  localparam int SEG_MAX  = (1 << SEG_BITS) - 1;
  localparam int SEG_TOP  = (MAX_ENTRIES - 1 < SEG_MAX) ? MAX_ENTRIES - 1 : SEG_MAX;

  logic [SEG_BITS-1:0] seg_raw_r;
  logic [SEG_BITS-1:0] seg_eff_r;
  logic [SEG_BITS-1:0] seg_eff_nxt;
  logic [SEG_BITS-1:0] wr_seg;
  logic                sel_seg;
  logic                wr_en;

  assign pready  = 1'b1;
  assign sel_seg = paddr[PADDR_BITS-1:2] == ADDR_SEGMENT_COUNT[PADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite && sel_seg;
  assign wr_seg  = pwdata[SEG_BITS-1:0];

  // zero acts as one segment; clamp to what the table holds
  always_comb begin
    seg_eff_nxt = wr_seg;
    if (wr_seg == '0) begin
      seg_eff_nxt = SEG_BITS'(1);
    end
    if (int'(seg_eff_nxt) > SEG_TOP) begin
      seg_eff_nxt = SEG_BITS'(SEG_TOP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_raw_r <= SEG_BITS'(1);
      seg_eff_r <= SEG_BITS'(1);
    end else if (wr_en) begin
      seg_raw_r <= wr_seg;
      seg_eff_r <= seg_eff_nxt;
    end
  end

  assign prdata    = sel_seg ? PDATA_BITS'(seg_raw_r) : '0;
  assign seg_count = seg_eff_r;

endmodule

// ===== rtl/uei_lerp_pipe.sv =====
`include "uniform_envelope_interpolator_defines.svh"

module uei_lerp_pipe #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_valid,
  input  uei_pkg::uei_meta_t      s1_meta,
  input  logic [2*VALUE_BITS-1:0] rd_a,
  input  logic [2*VALUE_BITS-1:0] rd_b,
  output logic                    go1,
  uei_out_if.source               out_ch
);
  import uei_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int DW = VB + 1;
  localparam int PW = DW + FRAC_BITS + 1;

  logic      v2_r, v3_r, v4_r;
  logic      go2, go3, go4;
  uei_meta_t s2_meta_r, s3_meta_r;
  logic      err4_r;

  logic signed [VB-1:0] a2_r [2];
  logic signed [DW-1:0] diff2_r [2];
  logic signed [VB-1:0] a3_r [2];
  logic signed [PW-1:0] prod3_r [2];
  logic signed [VB-1:0] res_r [2];

  // a stage takes new data when empty or when it drains this cycle
  assign go4 = !v4_r || out_ch.ready;
  assign go3 = !v3_r || go4;
  assign go2 = !v2_r || go3;
  assign go1 = !s1_valid || go2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (go2) v2_r <= s1_valid;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go2) s2_meta_r <= s1_meta;
    if (go3) s3_meta_r <= s2_meta_r;
    if (go4) err4_r    <= s3_meta_r.err;
  end

  // lane 0 is the lower envelope (upper half of the ram word), lane 1 the upper
  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic signed [VB-1:0]        a_word;
    logic signed [VB-1:0]        b_word;
    logic signed [DW-1:0]        diff_nxt;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PW-1:0]        prod_nxt;
    logic signed [VB-1:0]        res_nxt;

    assign a_word   = rd_a[(2-ln)*VB-1 -: VB];
    assign b_word   = rd_b[(2-ln)*VB-1 -: VB];
    assign diff_nxt = {b_word[VB-1], b_word} - {a_word[VB-1], a_word};
    assign frac_s   = $signed({1'b0, s2_meta_r.frac});
    assign prod_nxt = diff2_r[ln] * frac_s;
    // floor of diff*f/2^16 is an arithmetic shift; wraps into VB bits
    assign res_nxt  = s3_meta_r.err ? '0 : a3_r[ln] + prod3_r[ln][VB+FRAC_BITS-1:FRAC_BITS];

    always_ff @(posedge clk) begin
      if (go2) begin
        a2_r[ln]    <= a_word;
        diff2_r[ln] <= diff_nxt;
      end
      if (go3) begin
        a3_r[ln]    <= a2_r[ln];
        prod3_r[ln] <= prod_nxt;
      end
      if (go4) begin
        res_r[ln]   <= res_nxt;
      end
    end
  end

  assign out_ch.valid        = v4_r;
  assign out_ch.lower_result = res_r[0];
  assign out_ch.upper_result = res_r[1];
  assign out_ch.out_of_range = err4_r;

  `UEI_ASSERT_IMPLIES(a_err_zero, out_ch.valid && out_ch.out_of_range, out_ch.lower_result == '0 && out_ch.upper_result == '0)
  `UEI_ASSERT_NEXT(a_s3_hold, v3_r && !go3, v3_r && $stable(s3_meta_r))
  `UEI_ASSERT_IMPLIES(a_full_stall, !go1, s1_valid && v2_r && v3_r && v4_r)

endmodule

// ===== rtl/uniform_envelope_interpolator.sv =====
// Piecewise-linear lower/upper envelope interpolator over uniform breakpoints on [0,1].
// One beat is taken per clock unless stalled, writes and evaluations alike; a write
// stores an entry pair and returns nothing, an evaluation returns one beat after the
// ram read, difference, multiply and add stages, and stalls on the output back up
// only as far as the empty stages allow. The rate of one beat per clock is set by the
// table ram, which reads the two breakpoints of a segment through two read ports in
// the same cycle while writes use its single write port. A parameter above 1.0 returns
// zeros with out_of_range set. Table entries are undefined until written; the user
// must write segment count over the register port while the block is idle (unenforced).
`include "uniform_envelope_interpolator_defines.svh"

module uniform_envelope_interpolator #(
  parameter int MAX_ENTRIES = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  uei_in_if.sink                         in_ch,
  uei_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [uei_pkg::PADDR_BITS-1:0] paddr,
  input  logic [uei_pkg::PDATA_BITS-1:0] pwdata,
  output logic [uei_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);
  import uei_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int WW = 2 * VALUE_BITS;

  logic [SEG_BITS-1:0]    seg_count;
  logic                   go1;
  logic                   accept;
  logic                   is_eval;
  logic                   ram_we;
  logic                   ram_re;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          raddr_a;
  logic [AW-1:0]          raddr_b;
  logic [WW-1:0]          rd_a;
  logic [WW-1:0]          rd_b;
  logic [PROD_T_BITS-1:0] scaled_t;
  logic [IDX_BITS-1:0]    seg_idx;
  logic                   s1_valid_r;
  uei_meta_t              s1_meta_r;
  uei_meta_t              s1_meta_nxt;

  uei_cfg #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .seg_count (seg_count)
  );

  assign in_ch.ready = go1;
  assign accept      = in_ch.valid && go1;
  assign is_eval     = in_ch.command == CMD_EVAL;

  assign ram_we    = accept && (in_ch.command == CMD_WRITE) &&
                     (int'(in_ch.entry_index) < MAX_ENTRIES);
  assign ram_waddr = AW'(in_ch.entry_index);
  assign ram_re    = accept && is_eval;

  // t * n: integer part picks the segment, low 16 bits are the fraction.
  // With a zero fraction both reads point at the same entry, so at t = 1.0 the
  // lerp returns the last entry as is and nothing past it is read.
  assign scaled_t = PROD_T_BITS'(in_ch.param_t) * PROD_T_BITS'(seg_count);
  assign seg_idx  = scaled_t[PROD_T_BITS-1:FRAC_BITS];
  assign raddr_a  = AW'(seg_idx);
  assign raddr_b  = (scaled_t[FRAC_BITS-1:0] == '0) ? raddr_a :
                    AW'(seg_idx + IDX_BITS'(1));

  assign s1_meta_nxt.frac = scaled_t[FRAC_BITS-1:0];
  assign s1_meta_nxt.err  = in_ch.param_t > ONE_Q16;

  uei_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   ({in_ch.lower_value, in_ch.upper_value}),
    .re      (ram_re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (go1) begin
      s1_valid_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_meta_r <= s1_meta_nxt;
    end
  end

  uei_lerp_pipe #(
    .VALUE_BITS (VALUE_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_meta  (s1_meta_r),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .go1      (go1),
    .out_ch   (out_ch)
  );

  `UEI_ASSERT_IMPLIES(a_rw_excl, ram_we, !ram_re)
  `UEI_ASSERT_NEXT(a_read_lands, ram_re, s1_valid_r)
  `UEI_ASSERT_NEXT(a_no_phantom, go1 && !ram_re, !s1_valid_r)

endmodule

// ===== tb/sv/tb_uniform_envelope_interpolator.sv =====
`timescale 1ns / 100ps

module tb_uniform_envelope_interpolator;
  import uei_pkg::*;

  localparam int VBITS       = 32;
  localparam int N_ENTRIES   = 32;
  localparam int PHASE_ITEMS = 200;
  localparam int N_PHASES    = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_SLACK = 16;
  localparam int CYCLE_LIMIT = 500000;

  localparam logic signed [VBITS-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VBITS-1:0] VMAX = 32'sh7fff_ffff;

  typedef struct {
    logic                    cmd;
    logic [4:0]              idx;
    logic signed [VBITS-1:0] lo;
    logic signed [VBITS-1:0] up;
    logic [T_BITS-1:0]       t;
  } env_item_t;

  typedef struct {
    logic signed [VBITS-1:0] lo;
    logic signed [VBITS-1:0] up;
    logic                    oor;
  } env_result_t;

  typedef struct {
    env_item_t   item;
    bit          typed;
    env_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  uei_in_if  #(.VALUE_BITS(VBITS)) in_bus();
  uei_out_if #(.VALUE_BITS(VBITS)) out_bus();

  uniform_envelope_interpolator #(
    .MAX_ENTRIES(N_ENTRIES),
    .VALUE_BITS (VBITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [VBITS-1:0] lower_bp [N_ENTRIES];
  logic signed [VBITS-1:0] upper_bp [N_ENTRIES];
  logic [SEG_BITS-1:0]     seg_count_reg;
  env_result_t             envelope_expect_q[$];
  dir_row_t                dir_rows[$];

  int  err_count;
  int  cycle_cnt;
  int  n_writes;
  int  n_evals;
  int  n_oor;
  int  n_checked;
  int  n_settings;
  bit  src_idle;
  bit  snk_idle;
  bit  hold_request;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               envelope_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  // a + floor((b - a) * f / 2^16)
  function automatic logic signed [VBITS-1:0] lerp_q16(input logic signed [VBITS-1:0] a,
                                                       input logic signed [VBITS-1:0] b,
                                                       input logic [FRAC_BITS-1:0] f);
    longint d;
    longint s;
    d = longint'(b) - longint'(a);
    s = longint'(a) + ((d * longint'({1'b0, f})) >>> FRAC_BITS);
    return s[VBITS-1:0];
  endfunction

  function automatic env_result_t interpolate_envelopes(input logic [T_BITS-1:0] t);
    env_result_t        r;
    int unsigned        n;
    logic [21:0]        p;
    int unsigned        idx;
    logic [FRAC_BITS-1:0] f;
    r.lo  = '0;
    r.up  = '0;
    r.oor = 1'b0;
    if (t > ONE_Q16) begin
      r.oor = 1'b1;
      return r;
    end
    n   = (seg_count_reg == 0) ? 1 : seg_count_reg;
    p   = 22'(t * n);
    idx = int'(p[21:16]);
    f   = p[15:0];
    if (idx >= n) begin
      r.lo = lower_bp[n];
      r.up = upper_bp[n];
    end else begin
      r.lo = lerp_q16(lower_bp[idx], lower_bp[idx+1], f);
      r.up = lerp_q16(upper_bp[idx], upper_bp[idx+1], f);
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic cmd, input logic [4:0] idx,
                                      input logic signed [VBITS-1:0] lo,
                                      input logic signed [VBITS-1:0] up,
                                      input logic [T_BITS-1:0] t, input bit typed,
                                      input logic signed [VBITS-1:0] elo,
                                      input logic signed [VBITS-1:0] eup,
                                      input logic eoor);
    dir_row_t r;
    r.item.cmd = cmd;
    r.item.idx = idx;
    r.item.lo  = lo;
    r.item.up  = up;
    r.item.t   = t;
    r.typed    = typed;
    r.res.lo   = elo;
    r.res.up   = eup;
    r.res.oor  = eoor;
    return r;
  endfunction

  function automatic logic signed [VBITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VMIN;
      1:       return VMAX;
      2:       return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [T_BITS-1:0] rand_param();
    int unsigned n;
    int unsigned k;
    int unsigned t;
    n = (seg_count_reg == 0) ? 1 : seg_count_reg;
    case ($urandom_range(0, 19))
      0:       t = 0;
      1:       t = ONE_Q16;
      2:       t = ONE_Q16 + 1;
      3:       t = $urandom_range(ONE_Q16 + 1, 131071);
      4, 5: begin
        // land on or just below a segment boundary
        k = $urandom_range(0, n);
        t = (k * 65536 + n - 1) / n;
        if (k != 0 && $urandom_range(0, 1)) t = t - 1;
      end
      default: t = $urandom_range(0, ONE_Q16);
    endcase
    return t[T_BITS-1:0];
  endfunction

  function automatic env_item_t rand_item();
    env_item_t it;
    it.idx = 5'($urandom_range(0, N_ENTRIES - 1));
    it.lo  = rand_value();
    it.up  = rand_value();
    if ($urandom_range(0, 99) < 30) begin
      it.cmd = CMD_WRITE;
      it.t   = T_BITS'($urandom);
    end else begin
      it.cmd = CMD_EVAL;
      it.t   = rand_param();
    end
    return it;
  endfunction

  task automatic send_item(input env_item_t it);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= it.cmd;
    in_bus.entry_index <= it.idx;
    in_bus.lower_value <= it.lo;
    in_bus.upper_value <= it.up;
    in_bus.param_t     <= it.t;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic apply_item(input env_item_t it);
    if (it.cmd == CMD_WRITE) begin
      lower_bp[it.idx] = it.lo;
      upper_bp[it.idx] = it.up;
      n_writes++;
    end else begin
      envelope_expect_q.push_back(interpolate_envelopes(it.t));
      n_evals++;
      if (it.t > ONE_Q16) n_oor++;
    end
  endtask

  // writes carry no result, so leave room for any still in the pipe
  task automatic drain();
    while (envelope_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_segments(input logic [SEG_BITS-1:0] v);
    logic [PDATA_BITS-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SEGMENT_COUNT;
    pwdata  <= PDATA_BITS'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    seg_count_reg = v;
    n_settings++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // zero is remapped on use; its read-back is not checked
    if (v != 0 && rd !== PDATA_BITS'(v))
      flag_error($sformatf("segment_count read-back exp %0d got %0h", v, rd));
  endtask

  // result side: random ready gaps, one long hold on request
  initial begin
    int gap;
    env_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      gap = snk_idle ? $urandom_range(0, 16) : 0;
      @(negedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      if (envelope_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected beat lo=%0d up=%0d oor=%b", out_bus.lower_result,
                             out_bus.upper_result, out_bus.out_of_range));
      end else begin
        want = envelope_expect_q.pop_front();
        n_checked++;
        if (out_bus.lower_result !== want.lo)
          flag_error($sformatf("lower_result exp %0d got %0d", want.lo, out_bus.lower_result));
        if (out_bus.upper_result !== want.up)
          flag_error($sformatf("upper_result exp %0d got %0d", want.up, out_bus.upper_result));
        if (out_bus.out_of_range !== want.oor)
          flag_error($sformatf("out_of_range exp %b got %b", want.oor, out_bus.out_of_range));
      end
    end
  end

  initial begin
    logic [SEG_BITS-1:0] seg_plan [N_PHASES];
    env_item_t           it;
    dir_row_t            row;
    in_bus.valid       = 1'b0;
    in_bus.command     = CMD_WRITE;
    in_bus.entry_index = '0;
    in_bus.lower_value = '0;
    in_bus.upper_value = '0;
    in_bus.param_t     = '0;
    out_bus.ready      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    err_count          = 0;
    cycle_cnt          = 0;
    n_writes           = 0;
    n_evals            = 0;
    n_oor              = 0;
    n_checked          = 0;
    n_settings         = 0;
    src_idle           = 1'b1;
    snk_idle           = 1'b1;
    hold_request       = 1'b0;
    seg_count_reg      = 1;
    for (int i = 0; i < N_ENTRIES; i++) begin
      lower_bp[i] = '0;
      upper_bp[i] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one segment after reset: only entries 0 and 1 shape the results
    dir_rows.push_back(mk_row(CMD_WRITE, 0, VMIN, VMAX, 17'h1ffff, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_WRITE, 1, VMAX, VMIN, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 31, -1, -1, 0, 1, VMIN, VMAX, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, ONE_Q16, 1, VMAX, VMIN, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, ONE_Q16 + 1, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, 17'h1ffff, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, 32768, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, 65535, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_WRITE, 1, -1, 1, 0, 0, 0, 0, 0));
    // negative slope: floor goes toward minus infinity
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, 32768, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_WRITE, 0, 5, -5, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_WRITE, 1, 5, -5, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 0, 0, 0, 12345, 1, 5, -5, 0));
    dir_rows.push_back(mk_row(CMD_WRITE, 31, VMAX, VMIN, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_WRITE, 2, VMIN, VMAX, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_EVAL, 7, 1, 1, ONE_Q16, 1, 5, -5, 0));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.item);
      if (row.typed) begin
        envelope_expect_q.push_back(row.res);
        n_evals++;
        if (row.item.t > ONE_Q16) n_oor++;
      end else begin
        apply_item(row.item);
      end
    end

    // load every entry so no segment count reads an unwritten one
    for (int i = 0; i < N_ENTRIES; i++) begin
      it.cmd = CMD_WRITE;
      it.idx = 5'(i);
      it.lo  = rand_value();
      it.up  = rand_value();
      it.t   = T_BITS'($urandom);
      send_item(it);
      apply_item(it);
    end
    idle_input();
    drain();

    seg_plan = '{5'd31, 5'd1, 5'd0, 5'd2, 5'd31, 5'd5, 5'd1, 5'd1};
    seg_plan[6] = SEG_BITS'($urandom_range(1, 31));
    seg_plan[7] = SEG_BITS'($urandom_range(1, 31));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_segments(seg_plan[ph]);
      src_idle = (ph != 2 && ph != 4);
      snk_idle = (ph != 2 && ph != 4);
      if (ph == 4) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) begin
          idle_input();
          while (envelope_expect_q.size() != 0) @(posedge clk);
        end
        it = rand_item();
        send_item(it);
        apply_item(it);
      end
      idle_input();
      drain();
    end

    if (envelope_expect_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", envelope_expect_q.size()));

    $display("%0d evaluations (%0d above 1.0) and %0d table writes, %0d results checked",
             n_evals, n_oor, n_writes, n_checked);
    $display("%0d segment-count settings incl. 0 and 31, one %0d-cycle output stall",
             n_settings, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
